// ===== rtl/core/sgr_pkg.sv =====
// ============================================================================
// sgr_pkg
// Shared types, constants and tables of the scaled glyph rasterizer.
// ============================================================================
package sgr_pkg;

  // Largest magnification (1 or 2)
  localparam int MAX_SCALE = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 240;

  // Configuration register indexes
  localparam logic [1:0] CFG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] CFG_ROW_OFFSET    = 2'd3;

  // Result kinds (tuser)
  localparam logic STATUS_DRAWN    = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Decode stage -> font stage
  typedef struct packed {
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [5:0]  glyph;
    logic [15:0] fore;
    logic [15:0] back;
    logic        scale2;
    logic        reject;
  } sgr_dec_t;

  // Font stage -> row sequencer
  typedef struct packed {
    logic [39:0] cols;     // column 0 in bits 39:32, top row in bit 0 of each
    logic [15:0] fore;
    logic [15:0] back;
    logic [9:0]  xs;
    logic [9:0]  xe;
    logic [9:0]  ys;
    logic [9:0]  ye;
    logic        scale2;
    logic        reject;
  } sgr_item_t;

  // ASCII code -> font ROM index, lowercase folded, unknown -> blank
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    c = (code >= 8'h61 && code <= 8'h7A) ? (code - 8'd32) : code;
    idx = 6'd0;
    if (c == 8'h3A) idx = 6'd1;
    else if (c == 8'h2D) idx = 6'd2;
    else if (c >= 8'h30 && c <= 8'h39) idx = 6'd3 + 6'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h49) idx = 6'd13 + 6'(c - 8'h41);
    else if (c >= 8'h4B && c <= 8'h50) idx = 6'd22 + 6'(c - 8'h4B);
    else if (c >= 8'h52 && c <= 8'h5A) idx = 6'd28 + 6'(c - 8'h52);
    return idx;
  endfunction

  // 5x7 font ROM, five column bytes, column 0 first
  function automatic logic [39:0] font_cols(input logic [5:0] idx);
    logic [39:0] v;
    case (idx)
      6'd0:    v = 40'h0000000000;
      6'd1:    v = 40'h0036360000;
      6'd2:    v = 40'h0808080808;
      6'd3:    v = 40'h3E5149453E;
      6'd4:    v = 40'h00427F4000;
      6'd5:    v = 40'h4261514946;
      6'd6:    v = 40'h2141454B31;
      6'd7:    v = 40'h1814127F10;
      6'd8:    v = 40'h2745454539;
      6'd9:    v = 40'h3C4A494930;
      6'd10:   v = 40'h0171090503;
      6'd11:   v = 40'h3649494936;
      6'd12:   v = 40'h064949291E;
      6'd13:   v = 40'h7E1111117E;
      6'd14:   v = 40'h7F49494936;
      6'd15:   v = 40'h3E41414122;
      6'd16:   v = 40'h7F4141221C;
      6'd17:   v = 40'h7F49494941;
      6'd18:   v = 40'h7F09090901;
      6'd19:   v = 40'h3E4149497A;
      6'd20:   v = 40'h7F0808087F;
      6'd21:   v = 40'h00417F4100;
      6'd22:   v = 40'h7F08142241;
      6'd23:   v = 40'h7F40404040;
      6'd24:   v = 40'h7F020C027F;
      6'd25:   v = 40'h7F0408107F;
      6'd26:   v = 40'h3E4141413E;
      6'd27:   v = 40'h7F09090906;
      6'd28:   v = 40'h7F09192946;
      6'd29:   v = 40'h4649494931;
      6'd30:   v = 40'h01017F0101;
      6'd31:   v = 40'h3F4040403F;
      6'd32:   v = 40'h1F2040201F;
      6'd33:   v = 40'h3F4038403F;
      6'd34:   v = 40'h6314081463;
      6'd35:   v = 40'h0708700807;
      6'd36:   v = 40'h6151494543;
      default: v = 40'h0000000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/scaled_glyph_rasterizer_core.sv =====
// ============================================================================
// scaled_glyph_rasterizer_core
// Character generator: 5x7 font, 6x8 cell, scale 1..2, one result per row.
// ============================================================================
//
//  Channel  | Dir | Handshake             | Payload
//  ---------+-----+-----------------------+-----------------------------------
//  in_      | in  | in_tvalid / in_tready | in_tdata: draw request
//  out_     | out | out_tvalid/out_tready | out_tdata row, tuser status, tlast
//  cfg_     | in  | cfg_we (no wait)      | cfg_addr, cfg_wdata
//
//  Request goes through decode (clip), font/window and row sequencer stages.
//  The row sequencer emits one row per cycle while out_tready does not stall it:
//  8 rows per request at scale 1, 16 at scale 2, 1 for a rejected request. The
//  first result passes the decode, font, row-hold and output registers. Reset
//  (synchronous, rst_n low) empties all stages and loads panel 240x320, offsets 0.
//  A stall on out_tready holds every stage; nothing is dropped.
module scaled_glyph_rasterizer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // request: [9:0] pos_x, [19:10] pos_y, [27:20] char_code,
  //          [43:28] fore_color, [59:44] back_color, [67:60] scale_req, [71:68] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result: [9:0] win_x_start, [19:10] win_x_end, [29:20] win_y_start,
  //         [39:30] win_y_end, [43:40] row_number, [107:44] pixels_first,
  //         [171:108] pixels_second, [235:172] pixels_third, [239:236] pixels_in_row
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status: 0 drawn row, 1 rejected by clipping
  output logic                            out_tuser,
  // last_row
  output logic                            out_tlast,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [9:0]                      cfg_wdata
);
  import sgr_pkg::*;

  // configuration registers
  logic [9:0] panel_width_r, panel_height_r;
  logic [7:0] column_offset_r, row_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r   <= 10'd240;
      panel_height_r  <= 10'd320;
      column_offset_r <= 8'd0;
      row_offset_r    <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PANEL_WIDTH:   panel_width_r   <= cfg_wdata;
        CFG_PANEL_HEIGHT:  panel_height_r  <= cfg_wdata;
        CFG_COLUMN_OFFSET: column_offset_r <= cfg_wdata[7:0];
        CFG_ROW_OFFSET:    row_offset_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // stage links
  logic      dec_valid, dec_ready;
  sgr_dec_t  dec_data;
  logic      item_valid, item_ready;
  sgr_item_t item_data;

  // stage 1: clamp scale, glyph index, clip against panel
  sgr_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_data      (in_tdata),
    .panel_width  (panel_width_r),
    .panel_height (panel_height_r),
    .dec_valid    (dec_valid),
    .dec_ready    (dec_ready),
    .dec_data     (dec_data)
  );

  // stage 2: font ROM and window coordinates
  sgr_font u_font (
    .clk           (clk),
    .rst_n         (rst_n),
    .dec_valid     (dec_valid),
    .dec_ready     (dec_ready),
    .dec_data      (dec_data),
    .column_offset (column_offset_r),
    .row_offset    (row_offset_r),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item_data     (item_data)
  );

  // stage 3: row sequencer and output register
  sgr_rows u_rows (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/sgr_decode.sv =====
// ============================================================================
// sgr_decode
// Stage 1: scale clamp, glyph index lookup and panel clipping.
// ============================================================================
module sgr_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sgr_pkg::IN_TDATA_W-1:0] in_data,
  input  logic [9:0]                    panel_width,
  input  logic [9:0]                    panel_height,
  output logic                          dec_valid,
  input  logic                          dec_ready,
  output sgr_pkg::sgr_dec_t             dec_data
);
  import sgr_pkg::*;

  logic        valid_r, valid_nxt;
  sgr_dec_t    data_r, data_nxt;
  logic [9:0]  x, y;
  logic [7:0]  code, scale_req;
  logic        scale2;
  logic [10:0] x_end, y_end;
  logic        load;

  assign x         = in_data[9:0];
  assign y         = in_data[19:10];
  assign code      = in_data[27:20];
  assign scale_req = in_data[67:60];

  assign scale2 = (MAX_SCALE >= 2) && (scale_req >= 8'd2);
  assign x_end  = {1'b0, x} + (scale2 ? 11'd12 : 11'd6);
  assign y_end  = {1'b0, y} + (scale2 ? 11'd16 : 11'd8);

  assign in_ready = !valid_r || dec_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    data_nxt.pos_x  = x;
    data_nxt.pos_y  = y;
    data_nxt.glyph  = glyph_index(code);
    data_nxt.fore   = in_data[43:28];
    data_nxt.back   = in_data[59:44];
    data_nxt.scale2 = scale2;
    data_nxt.reject = (x >= panel_width) || (y >= panel_height) ||
                      (x_end > {1'b0, panel_width}) || (y_end > {1'b0, panel_height});
    valid_nxt = load ? 1'b1 : (dec_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

// ===== rtl/core/sgr_font.sv =====
// ============================================================================
// sgr_font
// Stage 2: font ROM read and controller window arithmetic.
// ============================================================================
module sgr_font (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dec_valid,
  output logic               dec_ready,
  input  sgr_pkg::sgr_dec_t  dec_data,
  input  logic [7:0]         column_offset,
  input  logic [7:0]         row_offset,
  output logic               item_valid,
  input  logic               item_ready,
  output sgr_pkg::sgr_item_t item_data
);
  import sgr_pkg::*;

  logic      valid_r, valid_nxt;
  sgr_item_t data_r, data_nxt;
  logic      load;
  logic [9:0] w_m1, h_m1;

  assign dec_ready = !valid_r || item_ready;
  assign load      = dec_valid && dec_ready;

  assign w_m1 = dec_data.scale2 ? 10'd11 : 10'd5;
  assign h_m1 = dec_data.scale2 ? 10'd15 : 10'd7;

  always_comb begin
    data_nxt.cols   = font_cols(dec_data.glyph);
    data_nxt.fore   = dec_data.fore;
    data_nxt.back   = dec_data.back;
    // window coordinates wrap at 1024
    data_nxt.xs     = dec_data.pos_x + {2'b00, column_offset};
    data_nxt.xe     = dec_data.pos_x + w_m1 + {2'b00, column_offset};
    data_nxt.ys     = dec_data.pos_y + {2'b00, row_offset};
    data_nxt.ye     = dec_data.pos_y + h_m1 + {2'b00, row_offset};
    data_nxt.scale2 = dec_data.scale2;
    data_nxt.reject = dec_data.reject;
    valid_nxt = load ? 1'b1 : (item_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item_data  = data_r;

endmodule

// ===== rtl/core/sgr_rows.sv =====
// ============================================================================
// sgr_rows
// Stage 3: row sequencer, one pixel row per cycle while the output is free.
// ============================================================================
module sgr_rows (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  sgr_pkg::sgr_item_t             item_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import sgr_pkg::*;

  logic      busy_r, busy_nxt;
  sgr_item_t hold_r;
  logic [3:0] row_r, row_nxt;
  logic      out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic      user_r, last_r;

  logic       out_free, emit, last, done, take;
  logic [2:0] grow;
  logic [7:0] col_byte [6];
  logic [191:0] pix;

  assign out_free   = !out_v_r || out_tready;
  assign emit       = busy_r && out_free;
  assign last       = hold_r.reject || (row_r == (hold_r.scale2 ? 4'd15 : 4'd7));
  assign done       = emit && last;
  assign item_ready = !busy_r || done;
  assign take       = item_valid && item_ready;

  assign grow = hold_r.scale2 ? row_r[3:1] : row_r[2:0];

  // pixel p sits at bits 191-16p of {first, second, third}
  always_comb begin
    logic [7:0] byte_sel;
    for (int k = 0; k < 5; k++) begin
      col_byte[k] = hold_r.cols[39-8*k -: 8];
    end
    col_byte[5] = 8'h00;
    pix = '0;
    for (int p = 0; p < 12; p++) begin
      if (hold_r.scale2) begin
        byte_sel = col_byte[3'(p/2)];
      end else if (p < 6) begin
        byte_sel = col_byte[3'(p)];
      end else begin
        byte_sel = 8'h00;
      end
      if (hold_r.scale2 || p < 6) begin
        pix[191-16*p -: 16] = byte_sel[grow] ? hold_r.fore : hold_r.back;
      end
    end
  end

  always_comb begin
    if (hold_r.reject) begin
      data_nxt = '0;
    end else begin
      data_nxt = {(hold_r.scale2 ? 4'd12 : 4'd6), pix[63:0], pix[127:64], pix[191:128],
                  row_r, hold_r.ye, hold_r.ys, hold_r.xe, hold_r.xs};
    end
    busy_nxt  = take ? 1'b1 : (done ? 1'b0 : busy_r);
    row_nxt   = take ? 4'd0 : (emit ? row_r + 4'd1 : row_r);
    out_v_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
      row_r   <= 4'd0;
    end else begin
      busy_r  <= busy_nxt;
      out_v_r <= out_v_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= item_data;
    end
    if (emit) begin
      data_r <= data_nxt;
      user_r <= hold_r.reject ? STATUS_REJECTED : STATUS_DRAWN;
      last_r <= last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  // row counter stays inside the cell at unit scale
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !hold_r.scale2 |-> row_r <= 4'd7)
    else $error("row counter past last unit-scale row");

  // a rejected request is always a single, final result
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("rejected result without last flag");

  // drawn rows carry 6 or 12 pixels
  a_pix_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[239:236] == 4'd6 || out_tdata[239:236] == 4'd12))
    else $error("bad pixel count on drawn row");

  // sequencer goes idle after the final row unless a new item is taken
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done && !take |=> !busy_r)
    else $error("sequencer busy after final row");

endmodule

// ===== tb/scaled_glyph_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_rasterizer_core_tb
// Self-checking regression of the glyph rasterizer: draw requests go in on
// the in_ stream, and every row or reject result is checked field by field
// against a local model of the font, clipping and window math. Both stream
// sides stall at random, and one long output hold fills the pipeline.
// ----------------------------------------------------------------------------
module scaled_glyph_rasterizer_core_tb;
  import sgr_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  RESET_CYCLES = 12;
  // settle time after the last expected result is back
  localparam int  SETTLE_CYCLES = 8;
  localparam int  HOLD_CYCLES = 400;

  // one expected result: a drawn row or a reject
  typedef struct packed {
    logic        status;
    logic [9:0]  xs;
    logic [9:0]  xe;
    logic [9:0]  ys;
    logic [9:0]  ye;
    logic [3:0]  row;
    logic [63:0] pix0;
    logic [63:0] pix1;
    logic [63:0] pix2;
    logic [3:0]  npix;
    logic        last;
  } glyph_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [1:0]             cfg_addr;
  logic [9:0]             cfg_wdata;

  // local copy of the panel registers
  int unsigned panel_w;
  int unsigned panel_h;
  int unsigned col_off;
  int unsigned row_off;

  glyph_row_t  expected_rows[$];
  int          mismatches = 0;

  // idle-free stretches on each side, and long-hold requests
  int          tx_calm = 0;
  int          rx_calm = 0;
  int          hold_requests = 0;

  // font: five column bytes per glyph, column 0 in bits 39:32, top row bit 0
  logic [39:0] glyph_font [0:36];

  string       char_pool =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz :-";

  always #HALF_PERIOD clk = ~clk;

  scaled_glyph_rasterizer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    glyph_font = '{
      40'h0000000000, 40'h0036360000, 40'h0808080808,   // blank : -
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946,   // 0 1 2
      40'h2141454B31, 40'h1814127F10, 40'h2745454539,   // 3 4 5
      40'h3C4A494930, 40'h0171090503, 40'h3649494936,   // 6 7 8
      40'h064949291E,                                   // 9
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,   // A B C
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,   // D E F
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,   // G H I
      40'h7F08142241, 40'h7F40404040, 40'h7F020C027F,   // K L M
      40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,   // N O P
      40'h7F09192946, 40'h4649494931, 40'h01017F0101,   // R S T
      40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,   // U V W
      40'h6314081463, 40'h0708700807, 40'h6151494543    // X Y Z
    };
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // ASCII to font slot; lowercase folds up, J, Q and the rest draw blank
  function automatic int font_slot(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c == ":") return 1;
    if (c == "-") return 2;
    if (c >= "0" && c <= "9") return 3 + int'(c - "0");
    if (c >= "A" && c <= "I") return 13 + int'(c - "A");
    if (c >= "K" && c <= "P") return 22 + int'(c - "K");
    if (c >= "R" && c <= "Z") return 28 + int'(c - "R");
    return 0;
  endfunction

  // queues every result one request causes
  function automatic void predict_glyph_rows(input logic [9:0] px, input logic [9:0] py,
                                             input logic [7:0] code,
                                             input logic [15:0] fg, input logic [15:0] bg,
                                             input logic [7:0] sc);
    int          s, w, h, x, y, r, p, grow, col;
    logic [39:0] glyph;
    logic [7:0]  bits;
    logic [63:0] words [0:2];
    glyph_row_t  rec;
    s = (sc == 8'd0) ? 1 : ((sc > 8'(MAX_SCALE)) ? MAX_SCALE : int'(sc));
    w = 6 * s;
    h = 8 * s;
    x = px;
    y = py;
    glyph = glyph_font[font_slot(code)];
    // clipping: the whole scaled cell must sit on the panel
    if (x >= panel_w || y >= panel_h || x + w > panel_w || y + h > panel_h) begin
      rec = '0;
      rec.status = STATUS_REJECTED;
      rec.last = 1'b1;
      expected_rows.push_back(rec);
      return;
    end
    for (r = 0; r < h; r++) begin
      words[0] = '0;
      words[1] = '0;
      words[2] = '0;
      grow = r / s;
      for (p = 0; p < w; p++) begin
        col = p / s;
        bits = (col < 5) ? glyph[39 - 8 * col -: 8] : 8'h00;  // sixth column spacing
        words[p / 4][63 - 16 * (p % 4) -: 16] = bits[grow] ? fg : bg;
      end
      rec.status = STATUS_DRAWN;
      rec.xs   = 10'(x + col_off);           // window wraps modulo 1024
      rec.xe   = 10'(x + w - 1 + col_off);
      rec.ys   = 10'(y + row_off);
      rec.ye   = 10'(y + h - 1 + row_off);
      rec.row  = 4'(r);
      rec.pix0 = words[0];
      rec.pix1 = words[1];
      rec.pix2 = words[2];
      rec.npix = 4'(w);
      rec.last = (r == h - 1);
      expected_rows.push_back(rec);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // per-request wait, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // register write; only called while the block is idle
  task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PANEL_WIDTH:   panel_w = val;
      CFG_PANEL_HEIGHT:  panel_h = val;
      CFG_COLUMN_OFFSET: col_off = val & 10'h0FF;
      CFG_ROW_OFFSET:    row_off = val & 10'h0FF;
      default: ;
    endcase
  endtask

  task automatic cfg_panel(input logic [9:0] w, input logic [9:0] h,
                           input logic [9:0] xo, input logic [9:0] yo);
    cfg_write(CFG_PANEL_WIDTH, w);
    cfg_write(CFG_PANEL_HEIGHT, h);
    cfg_write(CFG_COLUMN_OFFSET, xo);
    cfg_write(CFG_ROW_OFFSET, yo);
  endtask

  // offers one draw request and waits for its acceptance
  task automatic send_request(input logic [9:0] px, input logic [9:0] py,
                              input logic [7:0] code,
                              input logic [15:0] fg, input logic [15:0] bg,
                              input logic [7:0] sc);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, sc, bg, fg, code, py, px};
    do @(posedge clk); while (!in_tready);
    predict_glyph_rows(px, py, code, fg, bg, sc);
  endtask

  // mostly cells placed on the panel, some anywhere in the coordinate range
  task automatic send_random(input int count);
    int         n, s, w, h;
    logic [7:0] sc, code;
    logic [9:0] px, py;
    for (n = 0; n < count; n++) begin
      sc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 3));
      s = (sc == 8'd0) ? 1 : ((sc > 8'(MAX_SCALE)) ? MAX_SCALE : int'(sc));
      w = 6 * s;
      h = 8 * s;
      code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : char_pool[$urandom_range(0, char_pool.len() - 1)];
      if ($urandom_range(0, 4) != 0 && panel_w >= w)
        px = 10'($urandom_range(0, panel_w - w));
      else
        px = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 4) != 0 && panel_h >= h)
        py = 10'($urandom_range(0, panel_h - h));
      else
        py = 10'($urandom_range(0, 1023));
      send_request(px, py, code, 16'($urandom), 16'($urandom), sc);
    end
  endtask

  // stop offering, then wait until every expected result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset panel 240x320: glyph classes, scale clamp, exact fits and rejects
  task automatic test_reset_panel();
    send_request(10'd0,    10'd0,    " ",   16'h0000, 16'hFFFF, 8'd1);
    send_request(10'd234,  10'd312,  "0",   16'hFFFF, 16'h0000, 8'd1);  // exact fit
    send_request(10'd228,  10'd304,  "Z",   16'hF800, 16'h07E0, 8'd2);  // exact fit x2
    send_request(10'd235,  10'd0,    "A",   16'h1234, 16'h4321, 8'd1);  // right edge over
    send_request(10'd0,    10'd313,  "A",   16'h1234, 16'h4321, 8'd1);  // bottom over
    send_request(10'd240,  10'd0,    "B",   16'hAAAA, 16'h5555, 8'd1);  // x past panel
    send_request(10'd0,    10'd320,  "B",   16'hAAAA, 16'h5555, 8'd1);  // y past panel
    send_request(10'd1023, 10'd1023, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd255);
    send_request(10'd229,  10'd0,    "1",   16'h00FF, 16'hFF00, 8'd2);  // x2 over by one
    send_request(10'd10,   10'd20,   ":",   16'hFFFF, 16'h0000, 8'd0);  // scale 0 acts as 1
    send_request(10'd30,   10'd40,   "-",   16'h0F0F, 16'hF0F0, 8'd3);  // scale 3 acts as 2
    send_request(10'd50,   10'd60,   "9",   16'h8001, 16'h7FFE, 8'd255);
    send_request(10'd70,   10'd80,   "I",   16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd90,   10'd100,  "J",   16'hFFFF, 16'h0000, 8'd1);  // not in font
    send_request(10'd110,  10'd120,  "K",   16'hFFFF, 16'h0000, 8'd2);
    send_request(10'd130,  10'd140,  "P",   16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd150,  10'd160,  "Q",   16'hFFFF, 16'h0000, 8'd2);  // not in font
    send_request(10'd170,  10'd180,  "R",   16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd190,  10'd200,  "a",   16'h0001, 16'h8000, 8'd1);  // folds to A
    send_request(10'd200,  10'd220,  "z",   16'h0001, 16'h8000, 8'd2);  // folds to Z
    send_request(10'd0,    10'd240,  8'h00, 16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd20,   10'd260,  8'h80, 16'hFFFF, 16'h0000, 8'd1);  // high codes blank
    send_request(10'd40,   10'd280,  "@",   16'hFFFF, 16'h0000, 8'd1);
    wait_idle();
  endtask

  // largest panel, offsets at max: window coordinates wrap
  task automatic test_window_wrap();
    cfg_panel(10'd1023, 10'd1023, 10'h3FF, 10'h3FF);  // offsets keep only 8 bits
    send_request(10'd1017, 10'd1015, "W", 16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd1011, 10'd1007, "m", 16'h07E0, 16'h001F, 8'd2);
    send_request(10'd0,    10'd0,    "8", 16'hF81F, 16'h0000, 8'd2);
    send_request(10'd1012, 10'd0,    "X", 16'hFFFF, 16'h0000, 8'd2);  // over by one
    wait_idle();
  endtask

  // tiny panels: zero and one reject all, exactly one cell fits at scale 1
  task automatic test_panel_edges();
    cfg_panel(10'd0, 10'd0, 10'd0, 10'd0);
    send_request(10'd0, 10'd0, "0", 16'hFFFF, 16'h0000, 8'd1);
    wait_idle();
    cfg_panel(10'd1, 10'd1, 10'd17, 10'd33);
    send_request(10'd0, 10'd0, "1", 16'hFFFF, 16'h0000, 8'd1);
    wait_idle();
    cfg_panel(10'd6, 10'd8, 10'd255, 10'd0);
    send_request(10'd0, 10'd0, "H", 16'hFFFF, 16'h0000, 8'd1);
    send_request(10'd0, 10'd0, "H", 16'hFFFF, 16'h0000, 8'd2);  // x2 does not fit
    send_request(10'd1, 10'd0, "H", 16'hFFFF, 16'h0000, 8'd1);
    wait_idle();
    cfg_panel(10'd512, 10'd512, 10'd0, 10'd255);
    send_request(10'd500, 10'd496, "S", 16'hFFFF, 16'h0000, 8'd2);  // exact fit x2
    send_request(10'd506, 10'd504, "T", 16'hFFFF, 16'h0000, 8'd1);  // exact fit x1
    wait_idle();
  endtask

  // random requests over several panel settings
  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      cfg_panel(10'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                 : $urandom_range(64, 512)),
                10'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                 : $urandom_range(64, 512)),
                10'($urandom_range(0, 255)), 10'($urandom_range(0, 255)));
      send_random(26);
      wait_idle();
    end
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_output_stall();
    cfg_panel(10'd512, 10'd512, 10'($urandom_range(0, 255)), 10'($urandom_range(0, 255)));
    hold_requests++;
    tx_calm = 30;
    send_random(24);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_ready
    int rx_stall;
    int hold_served;
    int gap;
    rx_stall = 0;
    hold_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else begin
        if (hold_served != hold_requests) begin
          hold_served++;
          rx_stall = HOLD_CYCLES;
        end
        if (rx_stall > 0) begin
          out_tready <= 1'b0;
          rx_stall--;
        end else if (out_tvalid && out_tready) begin
          // a result went through at this edge: draw the next wait
          gap = draw_gap(rx_calm);
          if (gap == 0) begin
            out_tready <= 1'b1;
          end else begin
            out_tready <= 1'b0;
            rx_stall = gap - 1;
          end
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // every accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    glyph_row_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rows.size() == 0) begin
        $error("result with no request pending: tdata %0h", out_tdata);
        mismatches++;
      end else begin
        want = expected_rows.pop_front();
        check_field("status",        want.status, out_tuser);
        check_field("win_x_start",   want.xs,     out_tdata[9:0]);
        check_field("win_x_end",     want.xe,     out_tdata[19:10]);
        check_field("win_y_start",   want.ys,     out_tdata[29:20]);
        check_field("win_y_end",     want.ye,     out_tdata[39:30]);
        check_field("row_number",    want.row,    out_tdata[43:40]);
        check_field("pixels_first",  want.pix0,   out_tdata[107:44]);
        check_field("pixels_second", want.pix1,   out_tdata[171:108]);
        check_field("pixels_third",  want.pix2,   out_tdata[235:172]);
        check_field("pixels_in_row", want.npix,   out_tdata[239:236]);
        check_field("last_row",      want.last,   out_tlast);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_PANEL_WIDTH;
    cfg_wdata <= '0;
    panel_w = 240;
    panel_h = 320;
    col_off = 0;
    row_off = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_panel();
    test_window_wrap();
    test_panel_edges();
    test_random_traffic();
    test_output_stall();
    wait_idle();

    if (mismatches == 0) begin
      $display("scaled_glyph_rasterizer_core regression: pass");
    end else begin
      $display("scaled_glyph_rasterizer_core regression: fail");
    end
    $finish;
  end

  // hard limit: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("scaled_glyph_rasterizer_core regression: fail");
    $finish;
  end

endmodule
